/* sv/stx_bcd_length_lrc_deframer_assert.svh */
// Assertion macros for the STX / BCD length / LRC deframer.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef STX_BCD_LENGTH_LRC_DEFRAMER_ASSERT_SVH
`define STX_BCD_LENGTH_LRC_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SBLD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled during reset
`define SBLD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

/* sv/sbld_pkg.sv */
// Package for the STX / BCD length / LRC deframer: widths, phase type,
// status and register index codes. No dependencies.
`timescale 1ns / 1ps

package sbld_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 15;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_LEN_HI  = 6'b000010,
        PH_LEN_LO  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_END     = 6'b010000,
        PH_LRC     = 6'b100000
    } phase_t;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_START = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_END   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_LRC   = 2'd3;

    localparam logic [CIDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [CIDX_W-1:0] REG_START_BYTE  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_END_BYTE    = 2'd2;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 15'd1000;
    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd3;

    // four-nibble length, each nibble weighted as is (0..15)
    function automatic logic [LEN_W-1:0] bcd_length(input logic [BYTE_W-1:0] hi,
                                                    input logic [BYTE_W-1:0] lo);
        logic [LEN_W-1:0] sum;
        sum = LEN_W'(hi[7:4]) * 15'd1000
            + LEN_W'(hi[3:0]) * 15'd100
            + LEN_W'(lo[7:4]) * 15'd10
            + LEN_W'(lo[3:0]);
        return sum;
    endfunction

endpackage

/* sv/stx_bcd_length_lrc_deframer.sv */
// Top level of the STX / BCD length / XOR LRC deframer.
// Depends on sbld_pkg and stx_bcd_length_lrc_deframer_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | rx_byte
//  out     | out_valid/out_ready  | data_byte, data_valid, frame_done,
//          |                      | status, delivered_count
//
// One byte per cycle sustained; a request passes an input register and one
// decode stage into the result register.
// Bytes that raise no result retire without touching the result register.
// A held result stalls only a byte that would raise another one.
// Reset clears frame state and loads register defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`include "stx_bcd_length_lrc_deframer_assert.svh"

module stx_bcd_length_lrc_deframer
    import sbld_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [LEN_W-1:0]    cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   rx_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                data_valid,
    output logic                frame_done,
    output logic [STAT_W-1:0]   status,
    output logic [LEN_W-1:0]    delivered_count
);

    logic [LEN_W-1:0]   max_payload_reg;
    logic [BYTE_W-1:0]  start_byte_reg;
    logic [BYTE_W-1:0]  end_byte_reg;

    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]   decl_len_reg, decl_len_next;
    logic [LEN_W-1:0]   seen_reg, seen_next;
    logic [BYTE_W-1:0]  lrc_reg, lrc_next;
    logic               end_ok_reg, end_ok_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  data_byte_reg;
    logic               data_valid_reg;
    logic               frame_done_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [LEN_W-1:0]   count_reg;

    logic               res_valid;
    logic [BYTE_W-1:0]  res_byte;
    logic               res_dv;
    logic               res_fd;
    logic [STAT_W-1:0]  res_status;
    logic [LEN_W-1:0]   res_count;
    logic [LEN_W-1:0]   seen_inc;
    logic [LEN_W-1:0]   len_calc;
    logic               advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            start_byte_reg  <= START_BYTE_RST;
            end_byte_reg    <= END_BYTE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                REG_START_BYTE:  start_byte_reg  <= cfg_data[BYTE_W-1:0];
                REG_END_BYTE:    end_byte_reg    <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign seen_inc = seen_reg + 15'd1;
    assign len_calc = bcd_length(len_hi_reg, s1_byte_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        len_hi_next   = len_hi_reg;
        decl_len_next = decl_len_reg;
        seen_next     = seen_reg;
        lrc_next      = lrc_reg;
        end_ok_next   = end_ok_reg;
        res_valid     = 1'b0;
        res_byte      = '0;
        res_dv        = 1'b0;
        res_fd        = 1'b0;
        res_status    = ST_OK;
        res_count     = '0;
        case (phase_reg)
            PH_LEN_HI:
            begin
                len_hi_next = s1_byte_reg;
                lrc_next    = s1_byte_reg;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                decl_len_next = len_calc;
                lrc_next      = lrc_reg ^ s1_byte_reg;
                seen_next     = '0;
                phase_next    = (len_calc == '0) ? PH_END : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                lrc_next  = lrc_reg ^ s1_byte_reg;
                seen_next = seen_inc;
                if (seen_inc >= decl_len_reg)
                    phase_next = PH_END;
                if (seen_reg < max_payload_reg)
                begin
                    res_valid = 1'b1;
                    res_byte  = s1_byte_reg;
                    res_dv    = 1'b1;
                end
            end
            PH_END:
            begin
                end_ok_next = (s1_byte_reg == end_byte_reg);
                lrc_next    = lrc_reg ^ s1_byte_reg;
                phase_next  = PH_LRC;
            end
            PH_LRC:
            begin
                phase_next = PH_HUNT;
                res_valid  = 1'b1;
                res_fd     = 1'b1;
                res_count  = (decl_len_reg < max_payload_reg) ? decl_len_reg
                                                              : max_payload_reg;
                if (!end_ok_reg)
                    res_status = ST_BAD_END;
                else if (lrc_reg != s1_byte_reg)
                    res_status = ST_BAD_LRC;
                else
                    res_status = ST_OK;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (s1_byte_reg == start_byte_reg)
                    phase_next = PH_LEN_HI;
                else
                begin
                    res_valid  = 1'b1;
                    res_fd     = 1'b1;
                    res_status = ST_BAD_START;
                end
            end
        endcase
    end

    assign advance  = s1_valid_reg && (!res_valid || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign out_valid_next = (out_valid_reg && !out_ready) || (advance && res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            len_hi_reg    <= '0;
            decl_len_reg  <= '0;
            seen_reg      <= '0;
            lrc_reg       <= '0;
            end_ok_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                phase_reg    <= phase_next;
                len_hi_reg   <= len_hi_next;
                decl_len_reg <= decl_len_next;
                seen_reg     <= seen_next;
                lrc_reg      <= lrc_next;
                end_ok_reg   <= end_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= rx_byte;
        if (advance && res_valid)
        begin
            data_byte_reg  <= res_byte;
            data_valid_reg <= res_dv;
            frame_done_reg <= res_fd;
            status_reg     <= res_status;
            count_reg      <= res_count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign data_byte       = data_byte_reg;
    assign data_valid      = data_valid_reg;
    assign frame_done      = frame_done_reg;
    assign status          = status_reg;
    assign delivered_count = count_reg;

    // a result is either a payload byte or a frame report, never both
    `SBLD_ASSERT_IMP(a_one_kind, out_valid, data_valid ^ frame_done)
    // a rejected start byte reports nothing delivered
    `SBLD_ASSERT_IMP(a_bad_start_cnt, out_valid && frame_done && status == ST_BAD_START,
        delivered_count == '0)
    // the reported count never exceeds the delivery limit
    `SBLD_ASSERT_IMP(a_cnt_limit, out_valid && frame_done, delivered_count <= max_payload_reg)
    // a zero declared length never enters the payload phase
    `SBLD_ASSERT_NXT(a_len_nonzero, advance && phase_reg == PH_LEN_LO && len_calc == '0,
        phase_reg == PH_END)

endmodule

/* tb/sv/sbld_deframe_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the STX / BCD length / LRC deframer: follows register writes
// and accepted bytes, predicts each result and checks the output channel in order.
// Depends on sbld_pkg.

module sbld_deframe_checker
    import sbld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              data_valid,
    input  logic              frame_done,
    input  logic [STAT_W-1:0] status,
    input  logic [LEN_W-1:0]  delivered_count,
    output int                mismatches,
    output int                awaited_n,
    output int                bytes_checked,
    output int                frames_checked
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              dv;
        logic              fd;
        logic [STAT_W-1:0] st;
        logic [LEN_W-1:0]  cnt;
    } deframe_result_t;

    deframe_result_t   awaited_q[$];
    deframe_result_t   want;

    logic [LEN_W-1:0]  lim_payload;
    logic [BYTE_W-1:0] sof_byte;
    logic [BYTE_W-1:0] eof_byte;

    phase_t            ph;
    logic [BYTE_W-1:0] len_hi;
    logic [BYTE_W-1:0] lrc_acc;
    logic [LEN_W-1:0]  decl_len;
    logic [LEN_W-1:0]  payload_idx;
    logic              end_good;

    task report(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] deframer mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic deframe_result_t make_result(input logic [BYTE_W-1:0] db,
                                                    input logic dv, input logic fd,
                                                    input logic [STAT_W-1:0] st,
                                                    input logic [LEN_W-1:0] cnt);
        deframe_result_t r;
        r.data = db;
        r.dv   = dv;
        r.fd   = fd;
        r.st   = st;
        r.cnt  = cnt;
        return r;
    endfunction

    task predict_byte(input logic [BYTE_W-1:0] b);
        logic             deliver;
        logic [STAT_W-1:0] st;
        case (ph)
            PH_LEN_HI:
            begin
                len_hi  = b;
                lrc_acc = b;
                ph      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                // nibbles weighted as they stand, 0..15 each
                decl_len = LEN_W'(int'(len_hi[7:4]) * 1000 + int'(len_hi[3:0]) * 100
                                + int'(b[7:4]) * 10 + int'(b[3:0]));
                lrc_acc     = lrc_acc ^ b;
                payload_idx = '0;
                ph          = (decl_len == '0) ? PH_END : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                deliver     = payload_idx < lim_payload;
                lrc_acc     = lrc_acc ^ b;
                payload_idx = payload_idx + 1'b1;
                if (payload_idx >= decl_len)
                    ph = PH_END;
                if (deliver)
                    awaited_q.push_back(make_result(b, 1'b1, 1'b0, ST_OK, '0));
            end
            PH_END:
            begin
                end_good = (b == eof_byte);
                lrc_acc  = lrc_acc ^ b;
                ph       = PH_LRC;
            end
            PH_LRC:
            begin
                if (!end_good)
                    st = ST_BAD_END;
                else if (lrc_acc != b)
                    st = ST_BAD_LRC;
                else
                    st = ST_OK;
                awaited_q.push_back(make_result('0, 1'b0, 1'b1, st,
                                    (decl_len < lim_payload) ? decl_len : lim_payload));
                ph = PH_HUNT;
            end
            default:
            begin
                if (b == sof_byte)
                    ph = PH_LEN_HI;
                else
                begin
                    ph = PH_HUNT;
                    awaited_q.push_back(make_result('0, 1'b0, 1'b1, ST_BAD_START, '0));
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_payload    = MAX_PAYLOAD_RST;
            sof_byte       = START_BYTE_RST;
            eof_byte       = END_BYTE_RST;
            ph             = PH_HUNT;
            len_hi         = '0;
            lrc_acc        = '0;
            decl_len       = '0;
            payload_idx    = '0;
            end_good       = 1'b0;
            awaited_q.delete();
            mismatches     = 0;
            awaited_n      = 0;
            bytes_checked  = 0;
            frames_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_q.size() == 0)
                    report($sformatf("unasked result data=%02h dv=%0b fd=%0b st=%0d cnt=%0d",
                                     data_byte, data_valid, frame_done, status,
                                     delivered_count));
                else
                begin
                    want = awaited_q.pop_front();
                    if (data_byte !== want.data)
                        report($sformatf("data_byte %02h, want %02h", data_byte, want.data));
                    if (data_valid !== want.dv)
                        report($sformatf("data_valid %0b, want %0b", data_valid, want.dv));
                    if (frame_done !== want.fd)
                        report($sformatf("frame_done %0b, want %0b", frame_done, want.fd));
                    if (status !== want.st)
                        report($sformatf("status %0d, want %0d", status, want.st));
                    if (delivered_count !== want.cnt)
                        report($sformatf("delivered_count %0d, want %0d",
                                         delivered_count, want.cnt));
                    if (want.fd)
                        frames_checked++;
                    else
                        bytes_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAX_PAYLOAD: lim_payload = cfg_data;
                    REG_START_BYTE:  sof_byte    = cfg_data[BYTE_W-1:0];
                    REG_END_BYTE:    eof_byte    = cfg_data[BYTE_W-1:0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                predict_byte(rx_byte);
            awaited_n = awaited_q.size();
        end
    end

endmodule

/* tb/sv/tb_stx_bcd_length_lrc_deframer.sv */
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte and register requests,
// receiver back-pressure and the verdict.
// Depends on sbld_pkg, stx_bcd_length_lrc_deframer and sbld_deframe_checker.

module tb_stx_bcd_length_lrc_deframer;
    import sbld_pkg::*;

    localparam logic [CIDX_W-1:0] REG_SPARE   = 2'd3;
    localparam logic [LEN_W-1:0]  LEN_CEIL    = 15'd16665;
    localparam int                SETTLE_CYCLES = 8;
    localparam int                HOLD_CYCLES   = 300;
    localparam int                TAIL_CYCLES   = 20;
    localparam int                PHASE_ITEMS   = 192;
    localparam longint            WATCHDOG_NS   = 20_000_000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              frame_done;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  delivered_count;

    int mismatches;
    int awaited_n;
    int bytes_checked;
    int frames_checked;

    int bytes_sent     = 0;
    int settings_count = 0;
    int in_idle_pct    = 0;
    int out_stall_pct  = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;

    logic [BYTE_W-1:0] cur_start = START_BYTE_RST;
    logic [BYTE_W-1:0] cur_end   = END_BYTE_RST;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stx_bcd_length_lrc_deframer i_dut (.*);

    sbld_deframe_checker i_check (.*);

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_n != 0);
    endtask

    task settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_reg(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task apply_settings(input logic [LEN_W-1:0] lim, input logic [BYTE_W-1:0] sb,
                        input logic [BYTE_W-1:0] eb);
        logic [LEN_W-1:0] word;
        write_reg(REG_MAX_PAYLOAD, lim);
        // upper bits of the byte registers are don't-care
        word = LEN_W'($urandom);
        word[BYTE_W-1:0] = sb;
        write_reg(REG_START_BYTE, word);
        word = LEN_W'($urandom);
        word[BYTE_W-1:0] = eb;
        write_reg(REG_END_BYTE, word);
        cfg_valid <= 1'b0;
        cur_start = sb;
        cur_end   = eb;
        settings_count++;
    endtask

    task send_frame(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
                    input bit end_ok, input bit lrc_ok, input bit cut_short);
        int                len;
        int                n;
        logic [BYTE_W-1:0] lrc;
        logic [BYTE_W-1:0] pb;
        logic [BYTE_W-1:0] eb;
        len = hi[7:4] * 1000 + hi[3:0] * 100 + lo[7:4] * 10 + lo[3:0];
        send_byte(cur_start);
        send_byte(hi);
        send_byte(lo);
        lrc = hi ^ lo;
        if (cut_short)
            n = (len == 0) ? 0 : $urandom_range(len - 1);
        else
            n = len;
        repeat (n)
        begin
            pb  = 8'($urandom_range(255));
            lrc = lrc ^ pb;
            send_byte(pb);
        end
        if (!cut_short)
        begin
            eb  = end_ok ? cur_end : cur_end ^ 8'($urandom_range(1, 255));
            lrc = lrc ^ eb;
            send_byte(eb);
            send_byte(lrc_ok ? lrc : lrc ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task run_traffic(input int n);
        int                first;
        int                r;
        int                ln;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        first = bytes_sent;
        while (bytes_sent - first < n)
        begin
            r = $urandom_range(99);
            if (r < 12)
                send_byte(8'($urandom_range(255)));
            else
            begin
                r  = $urandom_range(99);
                hi = '0;
                if (r < 60)
                begin
                    ln = $urandom_range(20);
                    lo = {4'(ln / 10), 4'(ln % 10)};
                end
                else if (r < 85)
                    lo = {4'($urandom_range(2)), 4'($urandom_range(15))};
                else if (r < 97)
                    lo = 8'($urandom_range(255));
                else
                begin
                    hi = 8'($urandom_range(1, 2));
                    lo = 8'($urandom_range(255));
                end
                send_frame(hi, lo, $urandom_range(99) < 90, $urandom_range(99) < 88,
                           $urandom_range(99) < 5);
            end
        end
    endtask

    task run_phase(input logic [LEN_W-1:0] lim, input logic [BYTE_W-1:0] sb,
                   input logic [BYTE_W-1:0] eb, input int idle, input int stall,
                   input bit poke_spare);
        settle();
        in_idle_pct    = idle;
        out_stall_pct <= stall;
        if (poke_spare)
            write_reg(REG_SPARE, LEN_W'($urandom));
        apply_settings(lim, sb, eb);
        run_traffic(PHASE_ITEMS);
    endtask

    initial
    begin
        #(WATCHDOG_NS);
        $display("watchdog expired with %0d results outstanding", awaited_n);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: bad starts, empty and short frames, bad end, bad LRC
        send_byte(8'h00);
        send_byte(8'hff);
        send_frame(8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        send_frame(8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
        send_frame(8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        send_frame(8'h00, 8'h01, 1'b1, 1'b0, 1'b0);

        // limit lowered between header and payload: second byte dropped
        send_byte(START_BYTE_RST);
        send_byte(8'h00);
        send_byte(8'h02);
        settle();
        write_reg(REG_MAX_PAYLOAD, 15'd1);
        cfg_valid <= 1'b0;
        send_byte(8'ha5);
        send_byte(8'h5a);
        send_byte(END_BYTE_RST);
        send_byte(8'h00 ^ 8'h02 ^ 8'ha5 ^ 8'h5a ^ END_BYTE_RST);

        // back to defaults, no idling; long receiver hold-off, then a full drain
        settle();
        apply_settings(MAX_PAYLOAD_RST, START_BYTE_RST, END_BYTE_RST);
        run_traffic(PHASE_ITEMS / 2);
        hold_req <= hold_req + 1;
        run_traffic(60);
        wait_drained();
        run_traffic(PHASE_ITEMS / 2 - 60);

        run_phase(15'd0, 8'h00, 8'hff, 67, 0, 1'b0);
        run_phase(LEN_CEIL, 8'hff, 8'h00, 0, 67, 1'b0);
        send_frame(8'h00, 8'hff, 1'b1, 1'b1, 1'b0);
        run_phase(15'd3, 8'($urandom_range(255)), 8'($urandom_range(255)), 33, 33, 1'b0);
        run_phase(15'd16383, 8'h7e, 8'h81, 0, 0, 1'b0);
        run_phase(15'($urandom_range(40)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 67, 0, 1'b0);
        run_phase(15'd5, 8'($urandom_range(255)), 8'($urandom_range(255)), 0, 67, 1'b0);
        run_phase(15'($urandom_range(16665)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 33, 33, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("summary: %0d bytes sent under %0d register settings, one 165-byte frame",
                 bytes_sent, settings_count);
        $display("summary: %0d delivered bytes and %0d frame reports compared",
                 bytes_checked, frames_checked);
        if (mismatches == 0 && awaited_n == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
